### design/tks_pkg.sv
// Shared types and state codes for the top-k softmax sampler.
package tks_pkg;

    typedef struct packed {
        logic signed [15:0] logit;
        logic [17:0]        token_index;
        logic [15:0]        random_draw;
        logic               last;
    } tks_item_t;

    typedef struct packed {
        logic [17:0] chosen_index;
        logic        overflow;
    } tks_result_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SUM,
        ST_TARGET,
        ST_SCAN,
        ST_OUT
    } tks_state_t;

    typedef struct packed {
        logic load;
        logic walk_start;
        logic scan_mode;
        logic calc_target;
        logic row_clear;
    } tks_cmd_t;

    typedef struct packed {
        logic walk_done;
    } tks_status_t;

endpackage

### design/tks_ctrl.sv
// Sequencer for row loading, weight summing and cumulative scan.
module tks_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 item_last,
    input  tks_pkg::tks_status_t status,
    output tks_pkg::tks_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);
    import tks_pkg::*;

    tks_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (item_last)
                    begin
                        cmd.walk_start = 1'b1;
                        state_next     = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                if (status.walk_done)
                begin
                    state_next = ST_TARGET;
                end
            end
            ST_TARGET:
            begin
                cmd.calc_target = 1'b1;
                cmd.walk_start  = 1'b1;
                cmd.scan_mode   = 1'b1;
                state_next      = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_mode = 1'b1;
                if (status.walk_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                done          = 1'b1;
                cmd.row_clear = 1'b1;
                state_next    = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

### design/tks_datapath.sv
// Candidate stores, weight pipeline, accumulators and selection registers.
module tks_datapath #(
    parameter int MAX_CANDIDATES    = 64,
    parameter int EXP_TABLE_ENTRIES = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tks_pkg::tks_item_t   item,
    input  logic                 cfg_write,
    input  logic [15:0]          cfg_data,
    input  tks_pkg::tks_cmd_t    cmd,
    output tks_pkg::tks_status_t status,
    output tks_pkg::tks_result_t result
);
    import tks_pkg::*;

    localparam int AW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
    localparam int CW = $clog2(MAX_CANDIDATES + 1);
    localparam int SW = 16 + CW;
    localparam int TW = $clog2(EXP_TABLE_ENTRIES);

    typedef logic [15:0] exp_tbl_t [EXP_TABLE_ENTRIES];

    // Entry j is round(65535 * e^(-j/16)), built in Q60 fixed point.
    function automatic exp_tbl_t build_exp();
        logic [63:0]  step;
        logic [63:0]  term;
        logic [63:0]  v;
        logic [63:0]  w;
        logic [127:0] pr;
        exp_tbl_t     t;
        step = 64'd1 << 60;
        term = 64'd1 << 60;
        term = term / 16;  step = step - term;
        term = term / 32;  step = step + term;
        term = term / 48;  step = step - term;
        term = term / 64;  step = step + term;
        term = term / 80;  step = step - term;
        term = term / 96;  step = step + term;
        term = term / 112; step = step - term;
        term = term / 128; step = step + term;
        term = term / 144; step = step - term;
        term = term / 160; step = step + term;
        term = term / 176; step = step - term;
        term = term / 192; step = step + term;
        term = term / 208; step = step - term;
        term = term / 224; step = step + term;
        term = term / 240; step = step - term;
        term = term / 256; step = step + term;
        term = term / 272; step = step - term;
        term = term / 288; step = step + term;
        term = term / 304; step = step - term;
        term = term / 320; step = step + term;
        v = 64'd1 << 60;
        for (int j = 0; j < EXP_TABLE_ENTRIES; j++)
        begin
            w    = (v + (64'd1 << 19)) >> 20;
            t[j] = 16'((64'd65535 * w + (64'd1 << 39)) >> 40);
            pr   = 128'(v) * 128'(step);
            v    = 64'((pr + (128'd1 << 59)) >> 60);
        end
        return t;
    endfunction

    localparam exp_tbl_t EXP_TBL = build_exp();

    logic signed [15:0] logit_mem [MAX_CANDIDATES];
    logic [17:0]        index_mem [MAX_CANDIDATES];

    logic [15:0]        inv_reg;
    logic [CW-1:0]      count_reg;
    logic signed [15:0] max_reg;
    logic               drop_reg;
    logic [15:0]        draw_reg;
    logic [AW-1:0]      addr_reg;
    logic               issue_reg;
    logic               v1_reg, v2_reg, v3_reg;
    logic signed [15:0] lg1_reg;
    logic [17:0]        tk1_reg, tk2_reg, tk3_reg;
    logic [31:0]        prod2_reg;
    logic [15:0]        w3_reg;
    logic [SW-1:0]      sum_reg, cum_reg, target_reg;
    logic               found_reg;
    logic [17:0]        chosen_reg, last_tk_reg;

    logic               room;
    logic [AW-1:0]      wr_addr;
    logic signed [16:0] diff;
    logic [15:0]        diff_mag;
    logic [20:0]        mag;
    logic [12:0]        mag_sat;
    logic [8:0]         slot;
    logic [TW-1:0]      slot_sat;
    logic [SW-1:0]      cum_next;
    logic [SW+15:0]     target_prod;

    assign room    = (count_reg < CW'(MAX_CANDIDATES));
    assign wr_addr = count_reg[AW-1:0];
    assign diff    = 17'(max_reg) - 17'(lg1_reg);
    assign diff_mag = diff[16] ? 16'd0 : diff[15:0];

    always_comb
    begin
        mag     = 21'((33'(prod2_reg) + 33'd4095) >> 12);
        mag_sat = (mag > 21'd4096) ? 13'd4096 : mag[12:0];
        slot    = 9'((mag_sat + 13'd8) >> 4);
        if (32'(slot) > 32'(EXP_TABLE_ENTRIES - 1))
        begin
            slot_sat = TW'(EXP_TABLE_ENTRIES - 1);
        end
        else
        begin
            slot_sat = TW'(slot);
        end
    end

    assign cum_next    = cum_reg + SW'(w3_reg);
    assign target_prod = (SW + 16)'(draw_reg) * (SW + 16)'(sum_reg);

    // Stores: written during loading, read with a registered port while walking.
    always_ff @(posedge clk)
    begin
        if (cmd.load && room)
        begin
            logit_mem[wr_addr] <= item.logit;
            index_mem[wr_addr] <= item.token_index;
        end
        lg1_reg <= logit_mem[addr_reg];
        tk1_reg <= index_mem[addr_reg];
    end

    // Payload stages of the weight pipeline.
    always_ff @(posedge clk)
    begin
        prod2_reg <= 32'(diff_mag) * 32'(inv_reg);
        tk2_reg   <= tk1_reg;
        w3_reg    <= EXP_TBL[slot_sat];
        tk3_reg   <= tk2_reg;
        if (cmd.calc_target)
        begin
            target_reg <= SW'(target_prod >> 16);
        end
        if (cmd.load && item.last)
        begin
            draw_reg <= item.random_draw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg     <= 16'd4096;
            count_reg   <= '0;
            max_reg     <= -16'sd32768;
            drop_reg    <= 1'b0;
            addr_reg    <= '0;
            issue_reg   <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            sum_reg     <= '0;
            cum_reg     <= '0;
            found_reg   <= 1'b0;
            chosen_reg  <= '0;
            last_tk_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                inv_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                if (room)
                begin
                    count_reg <= count_reg + 1'b1;
                    if (item.logit > max_reg)
                    begin
                        max_reg <= item.logit;
                    end
                end
                else
                begin
                    drop_reg <= 1'b1;
                end
            end
            if (cmd.row_clear)
            begin
                count_reg <= '0;
                max_reg   <= -16'sd32768;
                drop_reg  <= 1'b0;
            end

            v1_reg <= issue_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;

            if (cmd.walk_start)
            begin
                addr_reg  <= '0;
                issue_reg <= 1'b1;
                cum_reg   <= '0;
                found_reg <= 1'b0;
                if (!cmd.scan_mode)
                begin
                    sum_reg <= '0;
                end
            end
            else if (issue_reg)
            begin
                if (CW'(addr_reg) + 1'b1 >= count_reg)
                begin
                    issue_reg <= 1'b0;
                end
                else
                begin
                    addr_reg <= addr_reg + 1'b1;
                end
            end

            if (v3_reg)
            begin
                if (cmd.scan_mode)
                begin
                    cum_reg     <= cum_next;
                    last_tk_reg <= tk3_reg;
                    if (!found_reg && (cum_next >= target_reg))
                    begin
                        found_reg  <= 1'b1;
                        chosen_reg <= tk3_reg;
                    end
                end
                else
                begin
                    sum_reg <= sum_reg + SW'(w3_reg);
                end
            end
        end
    end

    assign status.walk_done    = !issue_reg && !v1_reg && !v2_reg && !v3_reg;
    assign result.chosen_index = found_reg ? chosen_reg : last_tk_reg;
    assign result.overflow     = drop_reg;

endmodule

### design/top_k_softmax_sampler_top.sv
// Top level of the top-k softmax sampler: controller plus datapath.
// A request that is not last is taken while busy is low; busy stays low after it.
// A last request starts two walks over the N stored candidates, the
// summing walk and then the scanning walk, each through the store read
// port and weight pipeline; busy stays high from then until the result
// strobe ends.
// Reset (rst_n, asynchronous, active low) empties the row and sets
// inv_temperature to 4096; the receiver cannot stall the one-cycle result.
module top_k_softmax_sampler_top #(
    parameter int MAX_CANDIDATES    = 64,
    parameter int EXP_TABLE_ENTRIES = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  tks_pkg::tks_item_t   item,
    input  logic                 cfg_write,
    input  logic [15:0]          cfg_data,
    output logic                 done,
    output tks_pkg::tks_result_t result
);
    import tks_pkg::*;

    // Commands from the sequencer and the walk status back to it.
    tks_cmd_t    cmd;
    tks_status_t status;

    // The controller accepts a request whenever it is loading; a last
    // request switches it into the summing and scanning walks.
    tks_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item_last (item.last),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done)
    );

    // The datapath holds the stores, the running maximum and the
    // table-driven weight pipeline shared by both walks.
    tks_datapath #(
        .MAX_CANDIDATES    (MAX_CANDIDATES),
        .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule

### test/top_k_softmax_sampler_top_tb.sv
// Self-checking testbench for the top-k softmax sampler: candidate rows in, one index per row out.
module top_k_softmax_sampler_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tks_pkg::*;

    localparam int ROW_CAP    = 64;
    localparam int EXP_SLOTS  = 256;
    localparam int TEMP_ONE   = 4096;
    localparam int TEMP_MAX   = 65535;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    tks_item_t   item = '0;
    logic        cfg_write = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        done;
    tks_result_t result;

    top_k_softmax_sampler_top DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .cfg_write(cfg_write), .cfg_data(cfg_data), .done(done), .result(result)
    );

    always #5 clk = ~clk;

    // Mirror of the sampler state, kept in step with every accepted request.
    longint unsigned exp_weight [EXP_SLOTS];
    logic [15:0]     inv_temp;
    logic signed [15:0] row_logit [ROW_CAP];
    logic [17:0]     row_token [ROW_CAP];
    int              row_fill;
    logic signed [15:0] row_peak;
    logic            row_spilled;

    tks_result_t     pending_picks [$];
    int              error_count = 0;
    int              burst_left = 0;

    // The exponential table is rebuilt in Q60 integers: e^(-1/16) by its
    // alternating series, then repeated rounded products for each slot.
    task automatic build_exp_weights();
        longint unsigned step, term, v, w;
        logic [127:0] prod;
        step = 64'd1 << 60;
        term = 64'd1 << 60;
        v = 64'd1 << 60;
        for (int n = 1; n <= 20; n++)
        begin
            term = term / (16 * n);
            if (n % 2 == 1)
                step = step - term;
            else
                step = step + term;
        end
        for (int j = 0; j < EXP_SLOTS; j++)
        begin
            w = (v + (64'd1 << 19)) >> 20;
            exp_weight[j] = (65535 * w + (64'd1 << 39)) >> 40;
            prod = 128'(v) * 128'(step) + (128'd1 << 59);
            v = 64'(prod >> 60);
        end
    endtask

    // Weight of one stored candidate relative to the row maximum.
    function automatic longint unsigned weight_for(logic signed [15:0] lg);
        longint unsigned gap, mag, slot;
        if (lg > row_peak)
            return exp_weight[0];
        gap = longint'(row_peak) - longint'(lg);
        mag = (gap * inv_temp + 4095) >> 12;
        if (mag > 4096)
            mag = 4096;
        slot = (mag + 8) >> 4;
        if (slot > EXP_SLOTS - 1)
            slot = EXP_SLOTS - 1;
        return exp_weight[slot];
    endfunction

    // Updates the mirrored state for one accepted request and queues the
    // expected pick when the request closes the row.
    task automatic predict_pick(tks_item_t it);
        longint unsigned total, goal, acc;
        tks_result_t pick;
        if (row_fill < ROW_CAP)
        begin
            row_logit[row_fill] = it.logit;
            row_token[row_fill] = it.token_index;
            row_fill++;
            if (it.logit > row_peak)
                row_peak = it.logit;
        end
        else
            row_spilled = 1'b1;
        if (!it.last)
            return;
        total = 0;
        acc = 0;
        for (int i = 0; i < row_fill; i++)
            total += weight_for(row_logit[i]);
        goal = (longint'(it.random_draw) * total) >> 16;
        pick.chosen_index = row_token[row_fill - 1];
        for (int i = 0; i < row_fill; i++)
        begin
            acc += weight_for(row_logit[i]);
            if (acc >= goal)
            begin
                pick.chosen_index = row_token[i];
                break;
            end
        end
        pick.overflow = row_spilled;
        pending_picks.push_back(pick);
        row_fill = 0;
        row_peak = -16'sd32768;
        row_spilled = 1'b0;
    endtask

    task automatic report_mismatch(string what);
        error_count++;
        $display("ERROR at %0t: %s", $realtime, what);
    endtask

    // Results cannot be held off, so every strobe is checked on the edge
    // that ends it, against the oldest outstanding expectation.
    always @(posedge clk)
    begin
        tks_result_t want;
        if (rst_n && done)
        begin
            if (pending_picks.size() == 0)
                report_mismatch("result strobe with no row pending");
            else
            begin
                want = pending_picks.pop_front();
                if (result.chosen_index !== want.chosen_index)
                    report_mismatch($sformatf("chosen_index got %0d expected %0d",
                                              result.chosen_index, want.chosen_index));
                if (result.overflow !== want.overflow)
                    report_mismatch($sformatf("overflow got %0b expected %0b",
                                              result.overflow, want.overflow));
            end
        end
    end

    // Sends one request. The sender runs in bursts of random length with
    // random pauses; start stays high between back-to-back requests so that
    // it never gets two assignments on the same edge.
    task automatic send_candidate(logic signed [15:0] lg, logic [17:0] tok,
                                  logic [15:0] draw, logic lst);
        tks_item_t it;
        int pause;
        it.logit = lg;
        it.token_index = tok;
        it.random_draw = draw;
        it.last = lst;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            pause = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (pause > 0)
            begin
                start <= 1'b0;
                repeat (pause) @(posedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_pick(it);
    endtask

    // Lets the block drain: all picks in, busy low, then a short margin.
    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge clk);
        while (pending_picks.size() != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_temperature(logic [15:0] value);
        wait_quiet();
        cfg_write <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        inv_temp = value;
        @(posedge clk);
    endtask

    // One row of random length and content. Logits are either spread over
    // the full range or clustered so that the weights stay comparable.
    task automatic send_random_row(int len);
        int base, spread, v;
        logic [15:0] draw;
        base = $urandom_range(0, 65535) - 32768;
        spread = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 1024);
        draw = 16'($urandom_range(0, 65535));
        for (int i = 0; i < len; i++)
        begin
            v = (spread == 65535) ? int'($urandom_range(0, 65535)) - 32768
                                  : base + int'($urandom_range(0, spread)) - spread / 2;
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            send_candidate(16'(v), 18'($urandom_range(0, 262143)),
                           (i == len - 1) ? draw : 16'($urandom_range(0, 65535)),
                           i == len - 1);
        end
    endtask

    task automatic test_directed();
        // A single-candidate row must return that candidate.
        send_candidate(16'sh7FFF, 18'h3FFFF, 16'hFFFF, 1'b1);
        send_candidate(-16'sd32768, 18'h00000, 16'h0000, 1'b1);
        // Both extremes in one row, zero and full draw.
        send_candidate(-16'sd32768, 18'h15555, 16'h0000, 1'b0);
        send_candidate(16'sh7FFF, 18'h2AAAA, 16'h0000, 1'b1);
        send_candidate(-16'sd32768, 18'h15555, 16'h0000, 1'b0);
        send_candidate(16'sh7FFF, 18'h2AAAA, 16'hFFFF, 1'b1);
        // Equal logits: the draw splits the row evenly.
        for (int i = 0; i < 4; i++)
            send_candidate(16'sh0100, 18'(i + 10), 16'hC000, i == 3);
        // Exactly full row, no overflow.
        for (int i = 0; i < ROW_CAP; i++)
            send_candidate(16'(i * 16), 18'(i), 16'h8000, i == ROW_CAP - 1);
        // Overflow with the final two items dropped, then one whose last item is dropped.
        for (int i = 0; i < ROW_CAP + 2; i++)
            send_candidate(16'(-i * 8), 18'(1000 + i), 16'hFFFF, i == ROW_CAP + 1);
        for (int i = 0; i < ROW_CAP + 1; i++)
            send_candidate((i == ROW_CAP) ? 16'sh7FFF : 16'(i),
                           18'(2000 + i), 16'h4000, i == ROW_CAP);
    endtask

    task automatic test_temperatures();
        logic [15:0] temps [6] = '{16'd0, 16'd1, 16'(TEMP_MAX), 16'd2048,
                                   16'd40000, 16'(TEMP_ONE)};
        foreach (temps[t])
        begin
            write_temperature(temps[t]);
            for (int r = 0; r < 8; r++)
                send_random_row($urandom_range(1, 12));
        end
    endtask

    task automatic test_random_rows();
        int sent;
        sent = 0;
        while (sent < 400)
        begin
            int len;
            len = ($urandom_range(0, 11) == 0) ? $urandom_range(40, ROW_CAP + 6)
                                               : $urandom_range(1, 10);
            send_random_row(len);
            sent += len;
            if ($urandom_range(0, 60) == 0)
                write_temperature(16'($urandom_range(0, 65535)));
        end
    endtask

    initial
    begin
        build_exp_weights();
        inv_temp = 16'(TEMP_ONE);
        row_fill = 0;
        row_peak = -16'sd32768;
        row_spilled = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_temperatures();
        test_random_rows();
        wait_quiet();
        repeat (20) @(posedge clk);
        if (error_count == 0 && pending_picks.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

### sim.f
design/tks_pkg.sv
design/tks_ctrl.sv
design/tks_datapath.sv
design/top_k_softmax_sampler_top.sv
test/top_k_softmax_sampler_top_tb.sv
